### src/elf_hdr_pkg.sv
// ============================================================================
// elf_hdr_pkg
// Shared types, codes and the field position decoder of the ELF header parser.
// ============================================================================
`default_nettype none

package elf_hdr_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_CLASS = 2'd2;

    // Field ids
    localparam logic [4:0] FID_CLASS    = 5'd0;
    localparam logic [4:0] FID_ORDER    = 5'd1;
    localparam logic [4:0] FID_TYPE     = 5'd5;
    localparam logic [4:0] FID_MACHINE  = 5'd6;
    localparam logic [4:0] FID_VERSION  = 5'd7;
    localparam logic [4:0] FID_ENTRY    = 5'd8;
    localparam logic [4:0] FID_PHOFF    = 5'd9;
    localparam logic [4:0] FID_SHOFF    = 5'd10;
    localparam logic [4:0] FID_FLAGS    = 5'd11;
    localparam logic [4:0] FID_EHSIZE   = 5'd12;
    localparam logic [4:0] FID_SHSTRNDX = 5'd17;

    // Identification bytes
    localparam logic [7:0] MAGIC_E      = 8'h45;
    localparam logic [7:0] MAGIC_L      = 8'h4C;
    localparam logic [7:0] MAGIC_F      = 8'h46;
    localparam logic [7:0] CODE_ONE     = 8'h01;   // class 32 / little endian
    localparam logic [7:0] CODE_TWO     = 8'h02;   // class 64 / big endian

    // Byte positions in the identification area
    localparam logic [6:0] POS_MAG_LO   = 7'd1;
    localparam logic [6:0] POS_MAG_L    = 7'd2;
    localparam logic [6:0] POS_MAG_HI   = 7'd3;
    localparam logic [6:0] POS_CLASS    = 7'd4;
    localparam logic [6:0] POS_ORDER    = 7'd5;
    localparam logic [6:0] POS_ONE_LO   = 7'd6;
    localparam logic [6:0] POS_ONE_HI   = 7'd8;
    localparam logic [6:0] POS_MULTI    = 7'd16;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [63:0] field_value;
        logic [1:0]  status;
        logic        last_field;
    } result_t;

    typedef struct packed {
        logic       hit;       // position lies inside a multi-byte field
        logic [4:0] id;
        logic [2:0] off;       // byte offset inside the field
        logic       end_byte;  // final byte of the field
    } field_loc_t;

    // Map a byte position to its multi-byte field; address fields are 4 or 8 bytes.
    function automatic field_loc_t field_locate(input logic [6:0] pos, input logic wide);
        field_loc_t loc;
        logic [6:0] asz;
        logic [6:0] b9;
        logic [6:0] b10;
        logic [6:0] b11;
        logic [6:0] b12;
        logic [6:0] base;
        logic [6:0] sz;
        logic [6:0] rel;
        asz  = wide ? 7'd8 : 7'd4;
        b9   = 7'd24 + asz;
        b10  = b9 + asz;
        b11  = b10 + asz;
        b12  = b11 + 7'd4;
        rel  = pos - b12;
        loc  = '0;
        base = POS_MULTI;
        sz   = 7'd2;
        loc.hit = 1'b1;
        priority if (pos < POS_MULTI)
        begin
            loc.hit = 1'b0;
        end
        else if (pos < 7'd18)
        begin
            loc.id = FID_TYPE;    base = 7'd16; sz = 7'd2;
        end
        else if (pos < 7'd20)
        begin
            loc.id = FID_MACHINE; base = 7'd18; sz = 7'd2;
        end
        else if (pos < 7'd24)
        begin
            loc.id = FID_VERSION; base = 7'd20; sz = 7'd4;
        end
        else if (pos < b9)
        begin
            loc.id = FID_ENTRY;   base = 7'd24; sz = asz;
        end
        else if (pos < b10)
        begin
            loc.id = FID_PHOFF;   base = b9;    sz = asz;
        end
        else if (pos < b11)
        begin
            loc.id = FID_SHOFF;   base = b10;   sz = asz;
        end
        else if (pos < b12)
        begin
            loc.id = FID_FLAGS;   base = b11;   sz = 7'd4;
        end
        else if (pos < b12 + 7'd12)
        begin
            // six 2-byte fields, ehsize through shstrndx
            loc.id = FID_EHSIZE + {1'b0, rel[4:1]};
            base   = b12 + {rel[6:1], 1'b0};
            sz     = 7'd2;
        end
        else
        begin
            loc.hit = 1'b0;
        end
        loc.off      = 3'(pos - base);
        loc.end_byte = ((pos - base) == (sz - 7'd1));
        return loc;
    endfunction

endpackage

`default_nettype wire

### src/elf_hdr_in_if.sv
// ============================================================================
// elf_hdr_in_if
// Byte request channel into the ELF header parser.
// ============================================================================
`default_nettype none

interface elf_hdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_req;

    modport source (output valid, output data_byte, output start_req, input ready);
    modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

`default_nettype wire

### src/elf_hdr_out_if.sv
// ============================================================================
// elf_hdr_out_if
// Field result channel out of the ELF header parser.
// ============================================================================
`default_nettype none

interface elf_hdr_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  field_id;
    logic [63:0] field_value;
    logic [1:0]  status;
    logic        last_field;

    modport source (output valid, output field_id, output field_value, output status,
                    output last_field, input ready);
    modport sink   (input valid, input field_id, input field_value, input status,
                    input last_field, output ready);
endinterface

`default_nettype wire

### src/elf_hdr_core.sv
// ============================================================================
// elf_hdr_core
// Parse state and per-byte field assembly; one byte per accepted request.
// ============================================================================
`default_nettype none

module elf_hdr_core
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      accept,
    input  wire  [7:0]               data_byte,
    input  wire                      start_req,
    output logic                     res_valid,
    output elf_hdr_pkg::result_t     res
);
    import elf_hdr_pkg::*;

    logic [6:0]  pos_reg;
    logic [6:0]  pos_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        le_reg;
    logic        le_next;
    logic        wide_reg;
    logic        wide_next;
    logic        halted_reg;
    logic        halted_next;

    field_loc_t  loc;
    logic [7:0]  magic_exp;
    logic [63:0] acc_upd;

    assign loc = field_locate(pos_reg, wide_reg);

    always_comb
    begin
        unique case (pos_reg[1:0])
            2'd1:    magic_exp = MAGIC_E;
            2'd2:    magic_exp = MAGIC_L;
            default: magic_exp = MAGIC_F;
        endcase
    end

    always_comb
    begin
        if (le_reg)
            acc_upd = acc_reg | (64'(data_byte) << {loc.off, 3'b000});
        else
            acc_upd = {acc_reg[55:0], data_byte};
    end

    always_comb
    begin
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        le_next     = le_reg;
        wide_next   = wide_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (start_req)
        begin
            pos_next    = POS_MAG_LO;
            acc_next    = '0;
            le_next     = 1'b0;
            wide_next   = 1'b0;
            halted_next = 1'b0;
        end
        else if (!halted_reg)
        begin
            pos_next = pos_reg + 7'd1;
            priority if (pos_reg >= POS_MAG_LO && pos_reg <= POS_MAG_HI)
            begin
                if (data_byte != magic_exp)
                begin
                    halted_next     = 1'b1;
                    res_valid       = 1'b1;
                    res.field_id    = FID_CLASS;
                    res.status      = STATUS_MAGIC;
                    res.last_field  = 1'b1;
                end
            end
            else if (pos_reg == POS_CLASS)
            begin
                res_valid    = 1'b1;
                res.field_id = FID_CLASS;
                if (data_byte == CODE_ONE)
                begin
                    wide_next       = 1'b0;
                    res.field_value = 64'd32;
                end
                else if (data_byte == CODE_TWO)
                begin
                    wide_next       = 1'b1;
                    res.field_value = 64'd64;
                end
                else
                begin
                    halted_next    = 1'b1;
                    res.status     = STATUS_CLASS;
                    res.last_field = 1'b1;
                end
            end
            else if (pos_reg == POS_ORDER)
            begin
                // unknown codes keep the current (big endian) order
                if (data_byte == CODE_ONE)
                    le_next = 1'b1;
                else if (data_byte == CODE_TWO)
                    le_next = 1'b0;
                res_valid       = 1'b1;
                res.field_id    = FID_ORDER;
                res.field_value = 64'(le_next);
            end
            else if (pos_reg >= POS_ONE_LO && pos_reg <= POS_ONE_HI)
            begin
                res_valid       = 1'b1;
                res.field_id    = 5'(pos_reg - 7'd4);
                res.field_value = 64'(data_byte);
            end
            else if (loc.hit)
            begin
                acc_next = acc_upd;
                if (loc.end_byte)
                begin
                    acc_next        = '0;
                    res_valid       = 1'b1;
                    res.field_id    = loc.id;
                    res.field_value = acc_upd;
                    res.last_field  = (loc.id == FID_SHSTRNDX);
                    if (loc.id == FID_SHSTRNDX)
                        halted_next = 1'b1;
                end
            end
            else if (pos_reg >= POS_MULTI)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                // padding bytes: nothing to report
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            acc_reg    <= '0;
            le_reg     <= 1'b0;
            wide_reg   <= 1'b0;
            halted_reg <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            le_reg     <= le_next;
            wide_reg   <= wide_next;
            halted_reg <= halted_next;
        end
    end

`ifndef ASSERT_OFF
    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && res.status != STATUS_OK |=> halted_reg)
        else $error("error result did not halt the parser");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        !halted_reg |-> pos_reg >= POS_MAG_LO && pos_reg <= 7'd63)
        else $error("active parse outside header range");
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last_field |-> res.field_id == FID_SHSTRNDX
                                         || res.status != STATUS_OK)
        else $error("last mark on a non-final field");
    a_last_halts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && res.last_field |=> halted_reg)
        else $error("parser kept running after last field");
`endif

endmodule

`default_nettype wire

### src/elf_hdr_out_buf.sv
// ============================================================================
// elf_hdr_out_buf
// Two-entry result buffer; keeps the byte side moving while a result waits.
// ============================================================================
`default_nettype none

module elf_hdr_out_buf
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push,
    input  elf_hdr_pkg::result_t     push_data,
    output logic                     space,
    elf_hdr_out_if.source            out_ch
);
    import elf_hdr_pkg::*;

    result_t     ent_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;
    result_t     head;

    assign space = (count_reg != 2'd2);
    assign pop   = out_ch.valid && out_ch.ready;
    assign head  = ent_reg[rd_ptr_reg];

    assign out_ch.valid       = (count_reg != 2'd0);
    assign out_ch.field_id    = head.field_id;
    assign out_ch.field_value = head.field_value;
    assign out_ch.status      = head.status;
    assign out_ch.last_field  = head.last_field;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_data;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("result pushed into full buffer");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("buffer count out of range");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("buffer pointers disagree with count");
`endif

endmodule

`default_nettype wire

### src/elf_header_field_parser_top.sv
// ============================================================================
// elf_header_field_parser_top
// ELF file header parser: byte stream in, one request per decoded field out.
// ============================================================================
// Feed the header one byte per request, with start_req set on byte 0 (its
// data is ignored). The parser takes one byte every cycle while the output
// buffer has a free entry: each byte is decoded at accept time by a position
// compare plus a shift/OR into the field accumulator; any result goes into a
// two-entry output buffer, which offers it on out_ch. in_ch.ready only drops
// while both buffer entries hold results nobody has taken; it is registered
// and does not depend on out_ch.ready. Results: class (32/64), byte order
// (1 = little), ident version, os abi, abi version, then type through
// shstrndx assembled in the byte order read from byte 5; entry/phoff/shoff
// are 4 or 8 bytes by class. Padding bytes 9..15 give nothing. A bad magic
// (status 1) or a class other than 1 or 2 (status 2) gives one error result
// with last_field set, after which bytes are swallowed silently until the
// next start_req; the same holds after shstrndx, which also carries
// last_field. Out of reset the parser waits for a start.
// ============================================================================
`default_nettype none

module elf_header_field_parser_top
(
    input  wire             clk,
    input  wire             rst_n,
    elf_hdr_in_if.sink      in_ch,
    elf_hdr_out_if.source   out_ch
);
    import elf_hdr_pkg::*;

    logic    space;
    logic    accept;
    logic    res_valid;
    result_t res;

    // byte side moves whenever the buffer has a free entry
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    elf_hdr_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (in_ch.data_byte),
        .start_req (in_ch.start_req),
        .res_valid (res_valid),
        .res       (res)
    );

    elf_hdr_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .space     (space),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// ============================================================================
// tb
// Self-checking bench for the ELF header field parser.
// ============================================================================
// Bytes go in on in_ch, one request each. A tracker mirrors the parser state
// and queues the field results each accepted byte should cause; every result
// on out_ch is checked against the oldest queued one. A short directed
// section covers the reset wait, a failure at each magic byte, two bad
// classes and the odd byte-order code. Random whole headers of both classes
// and byte orders follow, mixed with truncated, corrupted and over-long
// ones. Both channels stall in random bursts.
// ============================================================================

module tb;

    import elf_hdr_pkg::*;

    localparam int REQUEST_TARGET = 650;   // requests the parser actually consumes
    localparam int QUIET_FROM     = 560;   // no idling from here on
    localparam int LONG_HOLD      = 200;   // cycles the receiver blocks once

    // ------------------------------------------------------------------------
    // Field tracker: own copy of the parser state plus the queue of fields
    // still owed by the block.
    // ------------------------------------------------------------------------
    class elf_field_tracker;
        logic [6:0]  pos;
        logic [63:0] acc;
        bit          little_end;
        bit          wide;
        bit          halted;
        result_t     owed_fields[$];
        int          errors;

        function new();
            pos        = '0;
            acc        = '0;
            little_end = 1'b0;
            wide       = 1'b0;
            halted     = 1'b1;
            errors     = 0;
        endfunction

        // Byte count of a multi-byte field
        function int field_bytes(int id);
            case (id)
                FID_VERSION, FID_FLAGS:
                    return 4;
                FID_ENTRY, FID_PHOFF, FID_SHOFF:
                    return wide ? 8 : 4;
                default:
                    return 2;
            endcase
        endfunction

        // Accepted request; returns 1 when the parser does not just drop it
        function bit note_byte(logic [7:0] b, logic s);
            result_t    r;
            logic [6:0] p;
            logic [7:0] want;
            bit         made;
            bit         found;
            int         base;
            int         sz;
            int         off;
            r    = '0;
            made = 1'b0;
            if (s)
            begin
                pos        = 7'd1;
                acc        = '0;
                little_end = 1'b0;
                wide       = 1'b0;
                halted     = 1'b0;
                return 1'b1;
            end
            if (halted)
                return 1'b0;
            p   = pos;
            pos = pos + 7'd1;
            if (p >= POS_MAG_LO && p <= POS_MAG_HI)
            begin
                want = (p == POS_MAG_LO) ? MAGIC_E : (p == POS_MAG_L) ? MAGIC_L : MAGIC_F;
                if (b != want)
                begin
                    halted       = 1'b1;
                    r.field_id   = FID_CLASS;
                    r.status     = STATUS_MAGIC;
                    r.last_field = 1'b1;
                    made         = 1'b1;
                end
            end
            else if (p == POS_CLASS)
            begin
                r.field_id = FID_CLASS;
                made       = 1'b1;
                if (b == CODE_ONE)
                begin
                    wide          = 1'b0;
                    r.field_value = 64'd32;
                end
                else if (b == CODE_TWO)
                begin
                    wide          = 1'b1;
                    r.field_value = 64'd64;
                end
                else
                begin
                    halted       = 1'b1;
                    r.status     = STATUS_CLASS;
                    r.last_field = 1'b1;
                end
            end
            else if (p == POS_ORDER)
            begin
                // unknown codes leave big endian in place
                if (b == CODE_ONE)
                    little_end = 1'b1;
                else if (b == CODE_TWO)
                    little_end = 1'b0;
                r.field_id    = FID_ORDER;
                r.field_value = {63'b0, little_end};
                made          = 1'b1;
            end
            else if (p >= POS_ONE_LO && p <= POS_ONE_HI)
            begin
                r.field_id    = 5'(p - 7'd4);
                r.field_value = {56'b0, b};
                made          = 1'b1;
            end
            else if (p >= POS_MULTI)
            begin
                base  = POS_MULTI;
                found = 1'b0;
                for (int id = FID_TYPE; id <= FID_SHSTRNDX && !found; id++)
                begin
                    sz = field_bytes(id);
                    if (p < base + sz)
                    begin
                        found = 1'b1;
                        off   = p - base;
                        if (little_end)
                            acc = acc | ({56'b0, b} << (8 * off));
                        else
                            acc = {acc[55:0], b};
                        if (off == sz - 1)
                        begin
                            r.field_id    = 5'(id);
                            r.field_value = acc;
                            r.last_field  = (id == FID_SHSTRNDX);
                            acc           = '0;
                            made          = 1'b1;
                            if (r.last_field)
                                halted = 1'b1;
                        end
                    end
                    base = base + sz;
                end
                if (!found)
                    halted = 1'b1;
            end
            // positions 9..15 are padding
            if (made)
                owed_fields.push_back(r);
            return 1'b1;
        endfunction

        // Accepted result against the oldest owed field
        function void check_field(logic [4:0] id, logic [63:0] value, logic [1:0] st,
                                  logic last);
            result_t want;
            if (owed_fields.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: id %0d value %h status %0d last %0b",
                         $time, id, value, st, last);
                return;
            end
            want = owed_fields.pop_front();
            if (id !== want.field_id)
            begin
                errors++;
                $display("%0t: field_id expected %0d, actual %0d", $time, want.field_id, id);
            end
            if (value !== want.field_value)
            begin
                errors++;
                $display("%0t: field_value expected %h, actual %h",
                         $time, want.field_value, value);
            end
            if (st !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d, actual %0d", $time, want.status, st);
            end
            if (last !== want.last_field)
            begin
                errors++;
                $display("%0t: last_field expected %0b, actual %0b",
                         $time, want.last_field, last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    elf_hdr_in_if  in_ch();
    elf_hdr_out_if out_ch();

    elf_header_field_parser_top i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    elf_field_tracker tracker;
    bit               quiet;          // end of run: both sides stream back to back
    bit               long_hold_req;  // sender asks the receiver for one long block
    int               consumed;       // requests that were not simply dropped
    int               tx_rate;        // sender gap chance in percent

    // ------------------------------------------------------------------------
    // Sender tasks; inputs move on the falling edge, ready is sampled on the
    // rising edge.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic s);
        if (!quiet && $urandom_range(1, 100) <= tx_rate)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.start_req <= s;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (tracker.note_byte(b, s))
            consumed++;
    endtask

    // Stop sending until every owed field came back
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (tracker.owed_fields.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] content_byte();
        case ($urandom_range(0, 7))
            0:
                return 8'h00;
            1:
                return 8'hFF;
            default:
                return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One header: mostly well formed, sometimes cut short by a new start,
    // corrupted in the identification bytes, or followed by bytes the
    // halted parser must swallow.
    task automatic send_header();
        logic [7:0] cls;
        logic [7:0] order;
        logic [7:0] b;
        int         kind;
        int         len;
        int         bad_pos;
        kind    = $urandom_range(0, 19);
        bad_pos = $urandom_range(1, 4);
        cls     = $urandom_range(0, 1) ? CODE_TWO : CODE_ONE;
        if (kind == 0)
            cls = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0, 1:
                order = CODE_ONE;
            2, 3:
                order = CODE_TWO;
            default:
                order = 8'($urandom_range(0, 255));
        endcase
        len = (cls == CODE_TWO) ? 64 : 52;
        if (kind == 1)
            len = $urandom_range(2, len - 1);
        else if (kind == 2)
            len = len + $urandom_range(1, 6);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        for (int i = 1; i < len; i++)
        begin
            case (i)
                POS_MAG_LO:
                    b = MAGIC_E;
                POS_MAG_L:
                    b = MAGIC_L;
                POS_MAG_HI:
                    b = MAGIC_F;
                POS_CLASS:
                    b = cls;
                POS_ORDER:
                    b = order;
                default:
                    b = content_byte();
            endcase
            if (kind == 3 && i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            send_byte(b, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts at a rate that changes during the run,
    // one long block on request, none at the end of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        int rx_rate;
        int tick;
        out_ch.ready = 1'b0;
        rx_rate      = 0;
        tick         = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            tick++;
            if (tick % 64 == 0)
                rx_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
            if (long_hold_req)
            begin
                // parser output buffer fills and in_ch.ready must drop
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(1, 100) <= rx_rate)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_field(out_ch.field_id, out_ch.field_value, out_ch.status,
                                out_ch.last_field);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int hdr;
        tracker         = new();
        quiet           = 1'b0;
        long_hold_req   = 1'b0;
        consumed        = 0;
        tx_rate         = 10;
        hdr             = 0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.start_req = 1'b0;
        rst_n           = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // out of reset the parser waits for a start: these are dropped
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(MAGIC_E, 1'b0);
        // magic broken at each of its three bytes
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(MAGIC_E, 1'b0);
        send_byte(MAGIC_E, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(MAGIC_E, 1'b0);
        send_byte(MAGIC_L, 1'b0);
        send_byte(8'hFF, 1'b0);
        // class 0 is an error too; the byte after it is swallowed
        send_byte(8'h00, 1'b1);
        send_byte(MAGIC_E, 1'b0);
        send_byte(MAGIC_L, 1'b0);
        send_byte(MAGIC_F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(MAGIC_E, 1'b0);
        // class 0xFF, then unknown byte-order code and a restart mid header
        send_byte(8'h00, 1'b1);
        send_byte(MAGIC_E, 1'b0);
        send_byte(MAGIC_L, 1'b0);
        send_byte(MAGIC_F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(MAGIC_E, 1'b0);
        send_byte(MAGIC_L, 1'b0);
        send_byte(MAGIC_F, 1'b0);
        send_byte(CODE_ONE, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_drained();

        // random headers until enough requests went through
        while (consumed < REQUEST_TARGET)
        begin
            if (hdr == 3)
                long_hold_req = 1'b1;
            if (hdr == 6)
                wait_drained();
            if (consumed >= QUIET_FROM)
                quiet = 1'b1;
            case ($urandom_range(0, 2))
                0:
                    tx_rate = 0;
                1:
                    tx_rate = 5;
                default:
                    tx_rate = 25;
            endcase
            send_header();
            hdr++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### elf_header_field_parser_top.f
src/elf_hdr_pkg.sv
src/elf_hdr_in_if.sv
src/elf_hdr_out_if.sv
src/elf_hdr_core.sv
src/elf_hdr_out_buf.sv
src/elf_header_field_parser_top.sv
tb/tb.sv
